// ----- rtl/prvc_pkg.sv -----
// ----------------------------------------------------------------------------
// prvc_pkg: shared types, constants and table builders
// Fixed-point formats, the request record handed from front to back, and
// elaboration-time builders for the CORDIC angle table and inverse gain.
// ----------------------------------------------------------------------------
package prvc_pkg;

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_FRAC_BITS     = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam int IN_W     = 32;   // width of the value fields
    localparam int GUARD    = 8;    // extra fraction bits on coordinates
    localparam int ANG_FRAC = 24;   // fraction bits of internal angles
    localparam int CW       = 44;   // coordinate width inside the CORDIC
    localparam int ZW       = 36;   // internal angle width
    localparam int GW       = 30;   // inverse gain width (Q30)
    localparam int TAB_LEN  = 32;

    localparam logic [1:0] FORM_RECT  = 2'd0;
    localparam logic [1:0] FORM_POLAR = 2'd1;

    localparam logic signed [ZW-1:0] HALF_Q24    = 36'sd3019898880;
    localparam logic signed [ZW-1:0] QUARTER_Q24 = 36'sd1509949440;
    localparam logic signed [ZW-1:0] FULL_Q24    = 36'sd6039797760;
    localparam logic [63:0]          FULL_U64    = 64'd6039797760;
    localparam logic [63:0]          DEG_PER_RAD_Q24 = 64'd961263669;

    // request record: classified item with its reduced rotation angle
    typedef struct packed {
        logic                   polar;
        logic                   bad;
        logic                   flip;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic signed [ZW-1:0]   r;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    // shift-subtract division, used only to build constants
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // atan(2^-i) in degrees, Q24, from the arctangent series
    function automatic logic [63:0] step_angle(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rq;
        int          e;
        sum = '0;
        if (i == 0) return 64'd45 << ANG_FRAC;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
                if ((k % 2) == 0) sum = sum + term;
                else sum = sum - term;
            end
        end
        rq = (sum + (64'd1 << 27)) >> 28;
        return (rq * DEG_PER_RAD_Q24 + (64'd1 << 31)) >> 32;
    endfunction

    function automatic logic [TAB_LEN*ZW-1:0] step_table();
        logic [TAB_LEN*ZW-1:0] t;
        t = '0;
        for (int i = 0; i < TAB_LEN; i++) begin
            t[i*ZW +: ZW] = ZW'(step_angle(i));
        end
        return t;
    endfunction

    // 1/K of an n-stage CORDIC in Q30
    function automatic logic [GW-1:0] inv_gain(input int n);
        logic [63:0] p;
        logic [63:0] s;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++) begin
            p = p + (p >> (2 * i));
        end
        s = isqrt64(p);
        return GW'(udiv64((64'd1 << 60) + (s >> 1), s));
    endfunction

    localparam logic [TAB_LEN*ZW-1:0] STEP_TAB = step_table();

endpackage

// ----- rtl/polar_rect_vector_converter_top.sv -----
// ----------------------------------------------------------------------------
// polar_rect_vector_converter_top: polar/rectangular vector converter
// Converts between polar and rectangular forms and reports x, y, length and
// angle of every vector, using pipelined CORDIC units.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one request per handshake: tdata holds the
//   first value (x or magnitude) and the second value (y or angle in degrees),
//   both signed Q15.16; tuser holds the form code (0 rectangular, 1 polar,
//   other codes give a zeroed vector with bad_form set).
//   Master channel m_axis returns one result per request, in order: x, y,
//   magnitude and angle in tdata, mode and bad_form flags in tuser.
//   Throughput: one request per cycle, sustained while the receiver takes
//   results, set by the fully pipelined front reduction stages and the two
//   CORDIC pipelines. A request accepted with no stall passes the modulo
//   reduction stages and the front's output register, the queue, the back
//   entry register, the rotation and vectoring pipelines and five gain,
//   select and rounding stages before its result is valid.
//   Reset (synchronous, active low) empties every pipeline and the queue; no
//   clearing pass is needed. When the receiver stalls, the back pipeline
//   holds, the four-entry queue absorbs the front's output, and s_axis_tready
//   drops once the queue is full.
// ----------------------------------------------------------------------------
module polar_rect_vector_converter_top
    import prvc_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [31:0] first_value, [63:32] second_value
    input  logic [1:0]   s_axis_tuser,   // [1:0] form_code
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // [31:0] x_out, [63:32] y_out,
                                         // [94:64] magnitude, [119:95] angle_deg
    output logic [1:0]   m_axis_tuser    // [0] mode_out, [1] bad_form
);

    logic               fr_valid;
    t_job               fr_job;
    logic               q_full;
    logic               q_valid;
    t_job               q_job;
    logic               bk_pop;
    logic signed [31:0] bk_x, bk_y;
    logic [30:0]        bk_mag;
    logic signed [24:0] bk_ang;
    logic               bk_mode, bk_bad;

    // accept, classify and reduce the angle
    prvc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_first  (s_axis_tdata[31:0]),
        .i_second (s_axis_tdata[63:32]),
        .i_form   (s_axis_tuser),
        .o_valid  (fr_valid),
        .o_job    (fr_job),
        .i_full   (q_full)
    );

    // decouple front and back so each can stall on its own
    prvc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_job),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    // rotate, apply gain, vector, round and saturate
    prvc_back #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (bk_pop),
        .i_job   (q_job),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_x     (bk_x),
        .o_y     (bk_y),
        .o_mag   (bk_mag),
        .o_ang   (bk_ang),
        .o_mode  (bk_mode),
        .o_bad   (bk_bad)
    );

    // pack the result fields, lowest field first
    assign m_axis_tdata = {bk_ang, bk_mag, bk_y, bk_x};
    assign m_axis_tuser = {bk_bad, bk_mode};

endmodule

// ----- rtl/prvc_front.sv -----
// ----------------------------------------------------------------------------
// prvc_front: request intake and angle reduction
// Classifies the form code and reduces a polar angle modulo 360 degrees,
// one quotient bit per stage, then folds it into +-90 degrees.
// ----------------------------------------------------------------------------
module prvc_front
    import prvc_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [IN_W-1:0] i_first,
    input  logic [IN_W-1:0] i_second,
    input  logic [1:0]      i_form,
    output logic            o_valid,
    output t_job            o_job,
    input  logic            i_full
);

    localparam int VW = IN_W + ANG_FRAC - FRAC_BITS;
    localparam int MW = VW + 1;
    localparam int QB = VW - IN_W;

    typedef struct packed {
        logic                   polar;
        logic                   bad;
        logic                   neg;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic [MW-1:0]          m;
    } t_fstage;

    logic    r_valid [0:QB];
    t_fstage r_st    [0:QB];
    t_fstage n_st    [0:QB];
    logic    r_job_valid;
    t_job    r_job;
    t_job    n_job;
    logic    en;
    logic signed [VW-1:0] bw;
    logic signed [ZW-1:0] rs;

    assign en      = !r_job_valid || !i_full;
    assign o_ready = en;
    assign o_valid = r_job_valid;
    assign o_job   = r_job;

    always_comb begin
        bw = VW'($signed(i_second)) <<< (VW - IN_W);
        n_st[0].polar = (i_form == FORM_POLAR);
        n_st[0].bad   = (i_form != FORM_RECT) && (i_form != FORM_POLAR);
        n_st[0].neg   = i_second[IN_W-1];
        n_st[0].a     = $signed(i_first);
        n_st[0].b     = $signed(i_second);
        n_st[0].m     = {1'b0, (i_second[IN_W-1] ? -bw : bw)};
        // one restoring step of the modulo per stage, largest multiple first
        for (int j = 1; j <= QB; j++) begin
            n_st[j] = r_st[j-1];
            if (r_st[j-1].m >= (MW'(FULL_U64) << (QB - j))) begin
                n_st[j].m = r_st[j-1].m - (MW'(FULL_U64) << (QB - j));
            end
        end
    end

    always_comb begin
        rs = ZW'({1'b0, r_st[QB].m[32:0]});
        if (r_st[QB].neg) rs = -rs;
        if (rs > HALF_Q24) rs = rs - FULL_Q24;
        if (rs <= -HALF_Q24) rs = rs + FULL_Q24;
        n_job.flip = 1'b0;
        if (rs > QUARTER_Q24) begin
            rs         = rs - HALF_Q24;
            n_job.flip = 1'b1;
        end else if (rs < -QUARTER_Q24) begin
            rs         = rs + HALF_Q24;
            n_job.flip = 1'b1;
        end
        n_job.polar = r_st[QB].polar;
        n_job.bad   = r_st[QB].bad;
        n_job.a     = r_st[QB].a;
        n_job.b     = r_st[QB].b;
        n_job.r     = rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QB; j++) r_valid[j] <= 1'b0;
            r_job_valid <= 1'b0;
        end else if (en) begin
            r_valid[0] <= i_valid;
            for (int j = 1; j <= QB; j++) r_valid[j] <= r_valid[j-1];
            r_job_valid <= r_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= QB; j++) r_st[j] <= n_st[j];
            r_job <= n_job;
        end
    end

endmodule

// ----- rtl/prvc_fifo.sv -----
// ----------------------------------------------------------------------------
// prvc_fifo: short request queue between front and back
// Register-based FIFO; the head entry is presented without a read delay.
// ----------------------------------------------------------------------------
module prvc_fifo
    import prvc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int PW = $clog2(DEPTH);

    t_job          r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (pop_ok) r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            r_count <= r_count + (PW+1)'(push_ok) - (PW+1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ----- rtl/prvc_cordic.sv -----
// ----------------------------------------------------------------------------
// prvc_cordic: pipelined CORDIC, one micro-rotation per stage
// Rotation mode steers by the residual angle, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module prvc_cordic
    import prvc_pkg::*;
#(
    parameter int   STAGES = DEF_CORDIC_STAGES,
    parameter logic VECTOR = 1'b0,
    parameter int   SBW    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [SBW-1:0]       i_sb,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [SBW-1:0]       o_sb
);

    logic                 r_valid [0:STAGES-1];
    logic signed [CW-1:0] r_x     [0:STAGES-1];
    logic signed [CW-1:0] r_y     [0:STAGES-1];
    logic signed [ZW-1:0] r_z     [0:STAGES-1];
    logic [SBW-1:0]       r_sb    [0:STAGES-1];
    logic signed [CW-1:0] s_x     [0:STAGES-1];
    logic signed [CW-1:0] s_y     [0:STAGES-1];
    logic signed [ZW-1:0] s_z     [0:STAGES-1];
    logic signed [CW-1:0] n_x     [0:STAGES-1];
    logic signed [CW-1:0] n_y     [0:STAGES-1];
    logic signed [ZW-1:0] n_z     [0:STAGES-1];
    logic                 pos     [0:STAGES-1];

    always_comb begin
        s_x[0] = i_x;
        s_y[0] = i_y;
        s_z[0] = i_z;
        for (int k = 1; k < STAGES; k++) begin
            s_x[k] = r_x[k-1];
            s_y[k] = r_y[k-1];
            s_z[k] = r_z[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            pos[k] = VECTOR ? s_y[k][CW-1] : !s_z[k][ZW-1];
            if (pos[k]) begin
                n_x[k] = s_x[k] - (s_y[k] >>> k);
                n_y[k] = s_y[k] + (s_x[k] >>> k);
                n_z[k] = s_z[k] - $signed(STEP_TAB[k*ZW +: ZW]);
            end else begin
                n_x[k] = s_x[k] + (s_y[k] >>> k);
                n_y[k] = s_y[k] - (s_x[k] >>> k);
                n_z[k] = s_z[k] + $signed(STEP_TAB[k*ZW +: ZW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) r_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STAGES; k++) begin
                r_x[k]  <= n_x[k];
                r_y[k]  <= n_y[k];
                r_z[k]  <= n_z[k];
                r_sb[k] <= (k == 0) ? i_sb : r_sb[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_x     = r_x[STAGES-1];
    assign o_y     = r_y[STAGES-1];
    assign o_z     = r_z[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];

endmodule

// ----- rtl/prvc_back.sv -----
// ----------------------------------------------------------------------------
// prvc_back: conversion pipeline
// Rotates polar requests to x/y, applies the gain, then vectors x/y into
// magnitude and angle; axis and zero vectors bypass the vectoring result.
// ----------------------------------------------------------------------------
module prvc_back
    import prvc_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  t_job                 i_job,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic signed [31:0]   o_x,
    output logic signed [31:0]   o_y,
    output logic [30:0]          o_mag,
    output logic signed [24:0]   o_ang,
    output logic                 o_mode,
    output logic                 o_bad
);

    localparam int PHW = CW - 32 + GW;
    localparam int PLW = 32 + GW;
    localparam logic [GW-1:0] INV_GAIN = inv_gain(CORDIC_STAGES);
    localparam int SH = ANG_FRAC - FRAC_BITS;
    localparam longint AHI_RAW = longint'(180) <<< FRAC_BITS;
    localparam longint AHI = (AHI_RAW < 64'sd16777215) ? AHI_RAW : 64'sd16777215;
    localparam longint ALO = (-AHI_RAW > -64'sd16777216) ? -AHI_RAW : -64'sd16777216;
    localparam logic signed [ZW:0] ANG_HI = (ZW+1)'(AHI);
    localparam logic signed [ZW:0] ANG_LO = (ZW+1)'(ALO);
    localparam logic signed [ZW:0] ANG_RND = (SH > 0) ? ((ZW+1)'(1) <<< ((SH > 0) ? SH - 1 : 0))
                                                      : '0;
    localparam logic signed [CW+1:0] I32_MAX = (CW+2)'(64'sd2147483647);
    localparam logic signed [CW+1:0] I32_MIN = -(CW+2)'(64'sd2147483648);

    typedef struct packed {
        logic              polar;
        logic              bad;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_sb1;

    typedef struct packed {
        logic                 polar;
        logic                 bad;
        logic signed [31:0]   x;
        logic signed [31:0]   y;
        logic                 spec;
        logic [32:0]          spec_mag;
        logic signed [ZW-1:0] spec_ang;
    } t_sb2;

    // round |v|*invK (Q30) back to the value field, restore sign, saturate
    function automatic logic signed [31:0] gain_sat(input logic sgn, input logic [PHW-1:0] phi,
                                                     input logic [PLW-1:0] plo);
        logic [CW:0]            m;
        logic [PLW:0]           lo_r;
        logic signed [CW+1:0]   sv;
        logic signed [CW+1:0]   rnd;
        lo_r = {1'b0, plo} + ((PLW+1)'(1) << 29);
        m    = (CW+1)'({phi, 2'b00}) + (CW+1)'(lo_r >> 30);
        sv   = $signed({1'b0, m});
        if (sgn) sv = -sv;
        rnd  = (sv + (CW+2)'(1 << (GUARD - 1))) >>> GUARD;
        if (rnd > I32_MAX) rnd = I32_MAX;
        if (rnd < I32_MIN) rnd = I32_MIN;
        return rnd[31:0];
    endfunction

    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_valid;

    // ---- entry stage
    logic                 r_b0_valid;
    logic signed [CW-1:0] r_b0_x;
    logic signed [ZW-1:0] r_b0_z;
    t_sb1                 r_b0_sb;
    logic signed [CW-1:0] n_b0_x;

    always_comb begin
        n_b0_x = CW'(i_job.a) <<< GUARD;
        if (i_job.flip) n_b0_x = -n_b0_x;
    end

    // ---- rotation
    logic                 rot_valid;
    logic signed [CW-1:0] rot_x;
    logic signed [CW-1:0] rot_y;
    t_sb1                 rot_sb;

    prvc_cordic #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b0),
        .SBW    ($bits(t_sb1))
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b0_valid),
        .i_x     (r_b0_x),
        .i_y     ('0),
        .i_z     (r_b0_z),
        .i_sb    (r_b0_sb),
        .o_valid (rot_valid),
        .o_x     (rot_x),
        .o_y     (rot_y),
        .o_z     (),
        .o_sb    (rot_sb)
    );

    // ---- gain products for x/y
    logic                 r_g1_valid;
    logic                 r_g1_sx, r_g1_sy;
    logic [PHW-1:0]       r_g1_phx, r_g1_phy;
    logic [PLW-1:0]       r_g1_plx, r_g1_ply;
    t_sb1                 r_g1_sb;
    logic [CW-1:0]        ux, uy;

    always_comb begin
        ux = rot_x[CW-1] ? CW'(-rot_x) : CW'(rot_x);
        uy = rot_y[CW-1] ? CW'(-rot_y) : CW'(rot_y);
    end

    // ---- x/y select
    logic                 r_g2_valid;
    logic signed [31:0]   r_g2_x, r_g2_y;
    logic                 r_g2_polar, r_g2_bad;
    logic signed [31:0]   n_g2_x, n_g2_y;

    always_comb begin
        priority if (r_g1_sb.polar) begin
            n_g2_x = gain_sat(r_g1_sx, r_g1_phx, r_g1_plx);
            n_g2_y = gain_sat(r_g1_sy, r_g1_phy, r_g1_ply);
        end else if (r_g1_sb.bad) begin
            n_g2_x = '0;
            n_g2_y = '0;
        end else begin
            n_g2_x = r_g1_sb.a;
            n_g2_y = r_g1_sb.b;
        end
    end

    // ---- vectoring entry: axis cases, half-plane fold
    logic                 r_v0_valid;
    logic signed [CW-1:0] r_v0_x, r_v0_y;
    logic signed [ZW-1:0] r_v0_z;
    t_sb2                 r_v0_sb;
    logic signed [CW-1:0] n_v0_x, n_v0_y;
    logic signed [ZW-1:0] n_v0_z;
    t_sb2                 n_v0_sb;
    logic                 xz, yz;
    logic signed [32:0]   ax, ay;

    always_comb begin
        xz = (r_g2_x == '0);
        yz = (r_g2_y == '0);
        ax = r_g2_x[31] ? -33'(r_g2_x) : 33'(r_g2_x);
        ay = r_g2_y[31] ? -33'(r_g2_y) : 33'(r_g2_y);
        n_v0_sb.polar = r_g2_polar;
        n_v0_sb.bad   = r_g2_bad;
        n_v0_sb.x     = r_g2_x;
        n_v0_sb.y     = r_g2_y;
        n_v0_sb.spec  = xz || yz;
        priority if (xz && yz) begin
            n_v0_sb.spec_mag = '0;
            n_v0_sb.spec_ang = '0;
        end else if (yz) begin
            n_v0_sb.spec_mag = ax;
            n_v0_sb.spec_ang = r_g2_x[31] ? HALF_Q24 : '0;
        end else begin
            n_v0_sb.spec_mag = ay;
            n_v0_sb.spec_ang = r_g2_y[31] ? -QUARTER_Q24 : QUARTER_Q24;
        end
        n_v0_x = CW'(r_g2_x) <<< GUARD;
        n_v0_y = CW'(r_g2_y) <<< GUARD;
        n_v0_z = '0;
        // left half-plane: turn by 180 degrees and start from that offset
        if (r_g2_x[31]) begin
            n_v0_x = -n_v0_x;
            n_v0_y = -n_v0_y;
            n_v0_z = r_g2_y[31] ? -HALF_Q24 : HALF_Q24;
        end
    end

    // ---- vectoring
    logic                 vec_valid;
    logic signed [CW-1:0] vec_x;
    logic signed [ZW-1:0] vec_z;
    t_sb2                 vec_sb;

    prvc_cordic #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b1),
        .SBW    ($bits(t_sb2))
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0_valid),
        .i_x     (r_v0_x),
        .i_y     (r_v0_y),
        .i_z     (r_v0_z),
        .i_sb    (r_v0_sb),
        .o_valid (vec_valid),
        .o_x     (vec_x),
        .o_y     (),
        .o_z     (vec_z),
        .o_sb    (vec_sb)
    );

    // ---- magnitude gain product
    logic                 r_g3_valid;
    logic                 r_g3_s;
    logic [PHW-1:0]       r_g3_ph;
    logic [PLW-1:0]       r_g3_pl;
    logic signed [ZW-1:0] r_g3_z;
    t_sb2                 r_g3_sb;
    logic [CW-1:0]        um;

    assign um = vec_x[CW-1] ? CW'(-vec_x) : CW'(vec_x);

    // ---- output register
    logic                 r_out_valid;
    logic signed [31:0]   r_out_x, r_out_y;
    logic [30:0]          r_out_mag;
    logic signed [24:0]   r_out_ang;
    logic                 r_out_mode, r_out_bad;
    logic signed [31:0]   gm;
    logic [32:0]          n_mag;
    logic signed [ZW:0]   an;
    logic signed [ZW:0]   ar;

    always_comb begin
        gm    = gain_sat(r_g3_s, r_g3_ph, r_g3_pl);
        n_mag = r_g3_sb.spec ? r_g3_sb.spec_mag : {1'b0, gm};
        if (n_mag > 33'h07FFFFFFF) n_mag = 33'h07FFFFFFF;
        an = r_g3_sb.spec ? (ZW+1)'(r_g3_sb.spec_ang) : (ZW+1)'(r_g3_z);
        ar = (an + ANG_RND) >>> SH;
        if (ar > ANG_HI) ar = ANG_HI;
        if (ar < ANG_LO) ar = ANG_LO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid  <= 1'b0;
            r_g1_valid  <= 1'b0;
            r_g2_valid  <= 1'b0;
            r_v0_valid  <= 1'b0;
            r_g3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b0_valid  <= i_valid;
            r_g1_valid  <= rot_valid;
            r_g2_valid  <= r_g1_valid;
            r_v0_valid  <= r_g2_valid;
            r_g3_valid  <= vec_valid;
            r_out_valid <= r_g3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b0_x        <= n_b0_x;
            r_b0_z        <= i_job.r;
            r_b0_sb.polar <= i_job.polar;
            r_b0_sb.bad   <= i_job.bad;
            r_b0_sb.a     <= i_job.a;
            r_b0_sb.b     <= i_job.b;

            r_g1_sx  <= rot_x[CW-1];
            r_g1_sy  <= rot_y[CW-1];
            r_g1_phx <= PHW'(ux[CW-1:32] * INV_GAIN);
            r_g1_phy <= PHW'(uy[CW-1:32] * INV_GAIN);
            r_g1_plx <= PLW'(ux[31:0] * INV_GAIN);
            r_g1_ply <= PLW'(uy[31:0] * INV_GAIN);
            r_g1_sb  <= rot_sb;

            r_g2_x     <= n_g2_x;
            r_g2_y     <= n_g2_y;
            r_g2_polar <= r_g1_sb.polar;
            r_g2_bad   <= r_g1_sb.bad;

            r_v0_x  <= n_v0_x;
            r_v0_y  <= n_v0_y;
            r_v0_z  <= n_v0_z;
            r_v0_sb <= n_v0_sb;

            r_g3_s  <= vec_x[CW-1];
            r_g3_ph <= PHW'(um[CW-1:32] * INV_GAIN);
            r_g3_pl <= PLW'(um[31:0] * INV_GAIN);
            r_g3_z  <= vec_z;
            r_g3_sb <= vec_sb;

            r_out_x    <= r_g3_sb.x;
            r_out_y    <= r_g3_sb.y;
            r_out_mag  <= n_mag[30:0];
            r_out_ang  <= ar[24:0];
            r_out_mode <= r_g3_sb.polar;
            r_out_bad  <= r_g3_sb.bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_out_x;
    assign o_y     = r_out_y;
    assign o_mag   = r_out_mag;
    assign o_ang   = r_out_ang;
    assign o_mode  = r_out_mode;
    assign o_bad   = r_out_bad;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_x == '0 && r_out_y == '0 && r_out_mag == '0
                                        && r_out_ang == '0 && !r_out_mode))
        else $error("invalid form result not zeroed");
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_x == '0 && r_out_y == '0) |-> (r_out_mag == '0 && r_out_ang == '0))
        else $error("zero vector with nonzero magnitude or angle");
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((ZW+1)'(r_out_ang) <= ANG_HI && (ZW+1)'(r_out_ang) >= ANG_LO))
        else $error("angle outside half turn");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g3_valid && !en) |=> r_g3_valid)
        else $error("pipeline lost a request while stalled");
`endif

endmodule

// ----- verif/tb_polar_rect_vector_converter_top.sv -----
// ----------------------------------------------------------------------------
// tb_polar_rect_vector_converter_top: self-checking bench for the converter
// Feeds directed and random rectangular, polar and invalid-form requests
// through the stream ports under several idling phases. A local bit-exact
// CORDIC model predicts every result and each returned result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_polar_rect_vector_converter_top;
    import prvc_pkg::*;

    localparam int  N_RANDOM  = 1500;
    localparam int  PAUSE_AT  = 120;    // sender drains the block here
    localparam int  HOLD_AT   = 260;    // receiver holds off from here
    localparam int  HOLD_LEN  = 400;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  DRAIN_WAIT = 100;
    localparam int  NSTAGE    = DEF_CORDIC_STAGES;
    localparam longint HALF_DEG    = longint'(180) << 24;
    localparam longint QUARTER_DEG = longint'(90) << 24;
    localparam longint FULL_DEG    = longint'(360) << 24;
    localparam longint INT32_LO    = -64'sd2147483648;
    localparam longint INT32_HI    = 64'sd2147483647;

    typedef struct {
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic [1:0]         form;
    } t_vec_req;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        mag;
        logic signed [24:0] ang;
        logic               mode;
        logic               bad;
    } t_vec_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;    // [31:0] first_value, [63:32] second_value
    logic [1:0]   s_axis_tuser;    // [1:0] form_code
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;    // [31:0] x, [63:32] y, [94:64] mag, [119:95] angle
    logic [1:0]   m_axis_tuser;    // [0] mode_out, [1] bad_form

    polar_rect_vector_converter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_vec_req pending_reqs[$];
    t_vec_res expected_res[$];
    t_vec_req cur_req;
    int       n_sent;
    int       n_total;
    int       n_err;
    bit       pause_done;
    bit       hold_done;
    int       hold_cnt;
    int       idle_cycles;

    longint   atan_tab[32];
    longint   inv_gain_q30;

    // ------------------------------------------------------------------
    // Fixed-point model of the converter
    // ------------------------------------------------------------------
    function automatic longint root64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // build atan(2^-i) in Q24 degrees and the inverse CORDIC gain
    function automatic void build_tables();
        longint unsigned sum;
        longint unsigned rq;
        longint unsigned p;
        longint unsigned s;
        longint unsigned e;
        atan_tab[0] = longint'(45) << 24;
        for (int i = 1; i < 32; i++) begin
            sum = 0;
            for (int k = 0; k < 32; k++) begin
                e = longint'(i) * (2 * k + 1);
                if (e > 60) break;
                if ((k & 1) == 0) sum = sum + ((64'd1 << (60 - e)) / (2 * k + 1));
                else sum = sum - ((64'd1 << (60 - e)) / (2 * k + 1));
            end
            rq = (sum + (64'd1 << 27)) >> 28;
            atan_tab[i] = longint'((rq * 64'd961263669 + (64'd1 << 31)) >> 32);
        end
        p = 64'd1 << 60;
        for (int i = 0; i < NSTAGE; i++) p = p + (p >> (2 * i));
        s = longint'(root64(p));
        inv_gain_q30 = longint'(((64'd1 << 60) + (s >> 1)) / s);
    endfunction

    function automatic longint round_shift(longint v, int s);
        if (s <= 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unscale(longint v);
        longint unsigned u;
        longint unsigned g;
        longint unsigned r;
        u = (v < 0) ? longint'(-v) : v;
        g = inv_gain_q30;
        r = (u >> 32) * g * 4 + (((u & 64'hFFFF_FFFF) * g + (64'd1 << 29)) >> 30);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_vec_res convert(t_vec_req q);
        t_vec_res res;
        longint a;
        longint b;
        longint x;
        longint y;
        longint mag;
        longint ang;
        longint r;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint offs;
        a = q.first;
        b = q.second;
        x = 0;
        y = 0;
        res.mode = 1'b0;
        res.bad  = 1'b0;
        if (q.form == FORM_RECT) begin
            x = a;
            y = b;
        end else if (q.form == FORM_POLAR) begin
            // reduce the angle into [-90, 90] and fold the sign into x
            r  = (b * 256) % FULL_DEG;
            cx = a * 256;
            cy = 0;
            if (r > HALF_DEG) r -= FULL_DEG;
            if (r <= -HALF_DEG) r += FULL_DEG;
            if (r > QUARTER_DEG) begin
                r -= HALF_DEG;
                cx = -cx;
            end else if (r < -QUARTER_DEG) begin
                r += HALF_DEG;
                cx = -cx;
            end
            for (int i = 0; i < NSTAGE; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (r >= 0) begin
                    cx -= dx; cy += dy; r -= atan_tab[i];
                end else begin
                    cx += dx; cy -= dy; r += atan_tab[i];
                end
            end
            x = clip(round_shift(unscale(cx), GUARD), INT32_LO, INT32_HI);
            y = clip(round_shift(unscale(cy), GUARD), INT32_LO, INT32_HI);
            res.mode = 1'b1;
        end else begin
            res.bad = 1'b1;
        end

        if (x == 0 && y == 0) begin
            mag = 0;
            ang = 0;
        end else if (y == 0) begin
            mag = (x < 0) ? -x : x;
            ang = (x > 0) ? 0 : HALF_DEG;
        end else if (x == 0) begin
            mag = (y < 0) ? -y : y;
            ang = (y > 0) ? QUARTER_DEG : -QUARTER_DEG;
        end else begin
            cx   = x * 256;
            cy   = y * 256;
            offs = 0;
            if (cx < 0) begin
                offs = (cy > 0) ? HALF_DEG : -HALF_DEG;
                cx = -cx;
                cy = -cy;
            end
            ang = 0;
            for (int i = 0; i < NSTAGE; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy < 0) begin
                    cx -= dx; cy += dy; ang -= atan_tab[i];
                end else begin
                    cx += dx; cy -= dy; ang += atan_tab[i];
                end
            end
            ang = ang + offs;
            mag = round_shift(unscale(cx), GUARD);
        end
        mag = clip(mag, 0, INT32_HI);
        ang = round_shift(ang, ANG_FRAC - DEF_FRAC_BITS);
        ang = clip(ang, -(longint'(180) << 16), longint'(180) << 16);
        ang = clip(ang, -(longint'(1) << 24), (longint'(1) << 24) - 1);
        res.x   = x[31:0];
        res.y   = y[31:0];
        res.mag = mag[30:0];
        res.ang = ang[24:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_vec_req mk(int f, int s, logic [1:0] form);
        t_vec_req q;
        q.first  = f;
        q.second = s;
        q.form   = form;
        return q;
    endfunction

    function automatic t_vec_req random_req();
        int unsigned sel;
        int          small_v;
        sel = $urandom_range(99);
        small_v = $signed($urandom) >>> $urandom_range(31, 8);
        if (sel < 30) return mk($urandom, $urandom, FORM_RECT);
        if (sel < 45) return mk(small_v, $signed($urandom) >>> 10, FORM_RECT);
        if (sel < 50) begin
            // point on an axis
            if ($urandom_range(1)) return mk(0, $urandom, FORM_RECT);
            return mk($urandom, 0, FORM_RECT);
        end
        if (sel < 80) return mk(small_v, $urandom, FORM_POLAR);
        if (sel < 88) return mk($urandom, $urandom, FORM_POLAR);
        if (sel < 94) begin
            // angle on a multiple of 90 degrees
            return mk(small_v, ($urandom_range(16) - 8) * (90 << 16), FORM_POLAR);
        end
        return mk($urandom, $urandom, 2'($urandom_range(3, 2)));
    endfunction

    // idle percentages per phase: none, sender, receiver, both
    function automatic int send_idle_pct();
        int ph;
        ph = (n_sent * 4) / n_total;
        return (ph == 1) ? 52 : ((ph == 3) ? 34 : 0);
    endfunction

    function automatic int recv_stall_pct();
        int ph;
        ph = (n_sent * 4) / n_total;
        return (ph == 2) ? 52 : ((ph == 3) ? 34 : 0);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: present pending requests, hold each until it is accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit busy;
        bit go;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_res.push_back(convert(cur_req));
                n_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                go = (pending_reqs.size() > 0) && ($urandom_range(99) >= send_idle_pct());
                // pause once until the block has drained completely
                if (n_sent == PAUSE_AT && !pause_done) begin
                    go = 1'b0;
                    if (expected_res.size() == 0) pause_done = 1'b1;
                end
                if (go) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {cur_req.second, cur_req.first};
                    s_axis_tuser <= cur_req.form;
                end
                s_axis_tvalid <= go;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result, drive ready with stalls and a long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_vec_res exp_r;
        bit       rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_res.size() == 0) begin
                    $error("unexpected result tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                    n_err++;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.x) begin
                        $error("x_out: expected %0d actual %0d", exp_r.x,
                               $signed(m_axis_tdata[31:0]));
                        n_err++;
                    end
                    if (m_axis_tdata[63:32] !== exp_r.y) begin
                        $error("y_out: expected %0d actual %0d", exp_r.y,
                               $signed(m_axis_tdata[63:32]));
                        n_err++;
                    end
                    if (m_axis_tdata[94:64] !== exp_r.mag) begin
                        $error("magnitude: expected %0d actual %0d", exp_r.mag,
                               m_axis_tdata[94:64]);
                        n_err++;
                    end
                    if (m_axis_tdata[119:95] !== exp_r.ang) begin
                        $error("angle_deg: expected %0d actual %0d", exp_r.ang,
                               $signed(m_axis_tdata[119:95]));
                        n_err++;
                    end
                    if (m_axis_tuser[0] !== exp_r.mode) begin
                        $error("mode_out: expected %0d actual %0d", exp_r.mode,
                               m_axis_tuser[0]);
                        n_err++;
                    end
                    if (m_axis_tuser[1] !== exp_r.bad) begin
                        $error("bad_form: expected %0d actual %0d", exp_r.bad,
                               m_axis_tuser[1]);
                        n_err++;
                    end
                end
            end
            rdy = ($urandom_range(99) >= recv_stall_pct());
            // hold off once so the queue fills and the input stalls
            if (n_sent >= HOLD_AT && !hold_done) begin
                rdy = 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_polar_rect_vector_converter_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: load requests, wait for drain, report
    // ------------------------------------------------------------------
    initial begin
        n_sent      = 0;
        n_err       = 0;
        pause_done  = 1'b0;
        hold_done   = 1'b0;
        hold_cnt    = 0;
        idle_cycles = 0;
        build_tables();

        // directed: extremes, zero vector, axes, invalid forms, odd angles
        pending_reqs.push_back(mk(0, 0, FORM_RECT));
        pending_reqs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, FORM_RECT));
        pending_reqs.push_back(mk(32'h8000_0000, 32'h8000_0000, FORM_RECT));
        pending_reqs.push_back(mk(32'h8000_0000, 0, FORM_RECT));
        pending_reqs.push_back(mk(0, 32'h8000_0000, FORM_RECT));
        pending_reqs.push_back(mk(5 << 16, 0, FORM_RECT));
        pending_reqs.push_back(mk(-(5 << 16), 0, FORM_RECT));
        pending_reqs.push_back(mk(0, 3 << 16, FORM_RECT));
        pending_reqs.push_back(mk(0, -(3 << 16), FORM_RECT));
        pending_reqs.push_back(mk(-(1 << 16), 1 << 16, FORM_RECT));
        pending_reqs.push_back(mk(-(1 << 16), -(1 << 16), FORM_RECT));
        pending_reqs.push_back(mk(0, 0, FORM_POLAR));
        pending_reqs.push_back(mk(2 << 16, 0, FORM_POLAR));
        pending_reqs.push_back(mk(2 << 16, 90 << 16, FORM_POLAR));
        pending_reqs.push_back(mk(2 << 16, 180 << 16, FORM_POLAR));
        pending_reqs.push_back(mk(2 << 16, -(180 << 16), FORM_POLAR));
        pending_reqs.push_back(mk(-(2 << 16), 30 << 16, FORM_POLAR));
        pending_reqs.push_back(mk(1 << 16, 32'h7FFF_FFFF, FORM_POLAR));
        pending_reqs.push_back(mk(1 << 16, 32'h8000_0000, FORM_POLAR));
        pending_reqs.push_back(mk(32'h7FFF_FFFF, 45 << 16, FORM_POLAR));
        pending_reqs.push_back(mk(32'h8000_0000, 200 << 16, FORM_POLAR));
        pending_reqs.push_back(mk(7 << 16, 7 << 16, 2'd2));
        pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
        for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(random_req());
        n_total = pending_reqs.size();

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_err == 0) begin
            $display("tb_polar_rect_vector_converter_top: clean");
        end else begin
            $display("tb_polar_rect_vector_converter_top: errors");
        end
        $finish;
    end

endmodule
